// ----- rtl/i2carb_pkg.sv -----
package i2carb_pkg;

  // Default number of client slots
  localparam int SLOT_COUNT_DEF = 4;

  // Slot / reply status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // One input transaction
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  handle;
    logic [7:0]  dev_addr;
    logic [31:0] buffer_ref;
    logic [15:0] length;
    logic [7:0]  repeat_start;
    logic [21:0] bus_freq;
    logic [1:0]  master_status;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  reply_status;
    logic        launch_valid;
    logic        launch_is_read;
    logic [3:0]  launch_slot;
    logic [7:0]  launch_addr;
    logic [31:0] launch_buffer;
    logic [15:0] launch_length;
    logic [7:0]  launch_repeat;
    logic [21:0] launch_freq;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the accepted transaction
    logic exec;  // evaluate it, update slots, register the result
  } ctrl_cmd_t;

endpackage

// ----- rtl/i2carb_ctrl.sv -----
module i2carb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output i2carb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Sequencing: capture, evaluate, present
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

// ----- rtl/i2carb_dp.sv -----
module i2carb_dp #(
  parameter int SLOT_COUNT = i2carb_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2carb_pkg::ctrl_cmd_t cmd,
  input  i2carb_pkg::in_item_t  in_item,
  output i2carb_pkg::out_item_t out_item
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Captured transaction and registered result
  i2carb_pkg::in_item_t  item_r;
  i2carb_pkg::out_item_t res_r;
  i2carb_pkg::out_item_t res_nxt;

  // Per-slot control state
  logic [1:0]            status_r   [SLOT_COUNT];
  logic [1:0]            status_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] active_r;
  logic [SLOT_COUNT-1:0] active_nxt;
  logic [SLOT_COUNT-1:0] phase_r;
  logic [SLOT_COUNT-1:0] phase_nxt;

  // Per-slot request data, valid once a request was taken
  logic        is_read_r [SLOT_COUNT];
  logic [7:0]  addr_r    [SLOT_COUNT];
  logic [31:0] buffer_r  [SLOT_COUNT];
  logic [15:0] length_r  [SLOT_COUNT];
  logic [7:0]  repeat_r  [SLOT_COUNT];
  logic [21:0] freq_r    [SLOT_COUNT];

  logic [IDX_W-1:0] hidx;
  logic             hdl_ok;
  logic [1:0]       mst;
  logic             act_found;
  logic [IDX_W-1:0] act_idx;
  logic             pend_found;
  logic [IDX_W-1:0] pend_idx;
  logic             req_wr;

  assign hidx   = item_r.handle[IDX_W-1:0];
  assign hdl_ok = ({1'b0, item_r.handle} < 5'(SLOT_COUNT));
  // master status code three counts as error
  assign mst    = (item_r.master_status == 2'd3) ? i2carb_pkg::ST_ERROR
                                                 : item_r.master_status;

  // Lowest active slot, and lowest pending slot that is not active
  always_comb begin
    act_found  = 1'b0;
    act_idx    = '0;
    pend_found = 1'b0;
    pend_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (active_r[i]) begin
        act_found = 1'b1;
        act_idx   = IDX_W'(i);
      end
      if (!active_r[i] && status_r[i] == i2carb_pkg::ST_BUSY) begin
        pend_found = 1'b1;
        pend_idx   = IDX_W'(i);
      end
    end
  end

  // Evaluate one transaction against the slot state
  always_comb begin
    status_nxt = status_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    res_nxt    = '0;
    req_wr     = 1'b0;
    res_nxt.reply_status = i2carb_pkg::ST_ERROR;
    case (item_r.mode)
      i2carb_pkg::MODE_TICK: begin
        res_nxt.reply_status = i2carb_pkg::ST_OK;
        if (!act_found) begin
          // promote the lowest pending slot, launch nothing
          if (pend_found) active_nxt[pend_idx] = 1'b1;
        end else if (!phase_r[act_idx]) begin
          // wait for an idle master, then launch
          if (mst != i2carb_pkg::ST_BUSY) begin
            res_nxt.launch_valid   = 1'b1;
            res_nxt.launch_is_read = is_read_r[act_idx];
            res_nxt.launch_slot    = 4'(act_idx);
            res_nxt.launch_addr    = addr_r[act_idx];
            res_nxt.launch_buffer  = buffer_r[act_idx];
            res_nxt.launch_length  = length_r[act_idx];
            res_nxt.launch_repeat  = is_read_r[act_idx] ? 8'd0 : repeat_r[act_idx];
            res_nxt.launch_freq    = freq_r[act_idx];
            status_nxt[act_idx]    = i2carb_pkg::ST_BUSY;
            phase_nxt[act_idx]     = 1'b1;
          end
        end else begin
          // follow the master until it settles
          status_nxt[act_idx] = mst;
          if (mst != i2carb_pkg::ST_BUSY) begin
            phase_nxt[act_idx]  = 1'b0;
            active_nxt[act_idx] = 1'b0;
          end
        end
      end
      i2carb_pkg::MODE_QUERY: begin
        if (hdl_ok) res_nxt.reply_status = status_r[hidx];
      end
      default: begin
        // write or read request
        if (hdl_ok && item_r.buffer_ref != 32'd0) begin
          if (status_r[hidx] == i2carb_pkg::ST_BUSY) begin
            res_nxt.reply_status = i2carb_pkg::ST_BUSY;
          end else begin
            req_wr               = 1'b1;
            status_nxt[hidx]     = i2carb_pkg::ST_BUSY;
            res_nxt.reply_status = i2carb_pkg::ST_OK;
          end
        end
      end
    endcase
  end

  // Transaction capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.exec) res_r  <= res_nxt;
  end

  // Slot control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status_r[i] <= i2carb_pkg::ST_ERROR;
      end
      active_r <= '0;
      phase_r  <= '0;
    end else if (cmd.exec) begin
      status_r <= status_nxt;
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // Slot request data
  always_ff @(posedge clk) begin
    if (cmd.exec && req_wr) begin
      is_read_r[hidx] <= (item_r.mode == i2carb_pkg::MODE_READ);
      addr_r[hidx]    <= item_r.dev_addr;
      buffer_r[hidx]  <= item_r.buffer_ref;
      length_r[hidx]  <= item_r.length;
      freq_r[hidx]    <= item_r.bus_freq;
      if (item_r.mode == i2carb_pkg::MODE_WRITE) repeat_r[hidx] <= item_r.repeat_start;
    end
  end

  assign out_item = res_r;

endmodule

// ----- rtl/i2c_multi_client_request_arbiter_unit.sv -----
// Fixed-priority request arbiter sharing one I2C master among client slots.
//
// Input channel: drive in_item and pulse start; the transaction is taken on
// a clock edge with start high and busy low. Modes: tick, write request,
// read request, status query. Ticks carry the master's current status.
//
// Result channel: exactly one result per transaction, shown on out_item for
// a single cycle with out_valid high. The receiver cannot stall it and must
// take it in that cycle.
//
// Timing: a taken transaction is captured, then evaluated in the execute
// state, where its result is registered, and presented in the done state
// with out_valid high. busy stays high through the done state, so the
// next transaction is taken only after the current result is presented.
// The cost is the capture, evaluate and present sequence of the
// controller; the slot search is a combinational priority encoder.
//
// Reset (rst_n low, synchronous): every slot becomes free with error
// status, inactive and waiting to launch; the controller returns to idle.
module i2c_multi_client_request_arbiter_unit #(
  parameter int SLOT_COUNT = i2carb_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  i2carb_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output i2carb_pkg::out_item_t out_item
);

  i2carb_pkg::ctrl_cmd_t cmd;

  i2carb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  i2carb_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // An accepted transaction holds the block busy with no result yet
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not raise busy");

  // Result strobe lasts one cycle and frees the input side
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe held or busy stuck");

  // A launch comes only from a tick, whose reply is ok
  a_launch_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.launch_valid) |->
      (out_item.reply_status == i2carb_pkg::ST_OK))
    else $error("launch with non-ok reply");

  // Without a launch all launch fields are zero
  a_launch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.launch_valid) |->
      (out_item.launch_buffer == 32'd0 && out_item.launch_slot == 4'd0))
    else $error("launch fields set without launch");

endmodule
